// ----- rtl/takf_pkg.sv -----
// Shared types, constants and the saturating helper function for the tilt angle filter
`default_nettype none
package takf_pkg;

   localparam int NumAxesDefault = 2;
   localparam int CfgWidth       = 24;
   localparam int CfgIdxWidth    = 2;
   localparam int StateWidth     = 32;
   localparam int AccWidth       = 25;
   localparam int DtWidth        = 24;
   localparam int ProdWidth      = 64;

   localparam logic [CfgIdxWidth-1:0] REG_Q_ANGLE = 2'd0;
   localparam logic [CfgIdxWidth-1:0] REG_Q_GYRO  = 2'd1;
   localparam logic [CfgIdxWidth-1:0] REG_R_ANGLE = 2'd2;

   // Multiplier operand select codes
   localparam logic [3:0] MUL_DT_RATE  = 4'd0;
   localparam logic [3:0] MUL_DT_QA    = 4'd1;
   localparam logic [3:0] MUL_DT_C01   = 4'd2;
   localparam logic [3:0] MUL_DT_C11   = 4'd3;
   localparam logic [3:0] MUL_DT_QG    = 4'd4;
   localparam logic [3:0] MUL_K0_Y     = 4'd5;
   localparam logic [3:0] MUL_K1_Y     = 4'd6;
   localparam logic [3:0] MUL_K0_P00   = 4'd7;
   localparam logic [3:0] MUL_K0_P01   = 4'd8;
   localparam logic [3:0] MUL_K1_P00   = 4'd9;
   localparam logic [3:0] MUL_K1_P01   = 4'd10;

   // Commands from controller to datapath
   typedef struct packed {
      logic       load;      // capture request and state
      logic       mul_go;    // register product for selected operands
      logic [3:0] mul_sel;
      logic       apply;     // apply registered product to its target
      logic       pred_p00;  // form S and innovation y
      logic       div_start; // start gain division
      logic       div_sel;   // 0 = K0, 1 = K1
      logic       k0_load;   // capture finished quotient as K0
      logic       k1_load;   // capture finished quotient as K1
      logic       store;     // write back state and result
   } takf_cmd_type;

   typedef struct packed {
      logic div_busy;
   } takf_sts_type;

   function automatic logic signed [StateWidth-1:0] sat32(
      input logic signed [ProdWidth+1:0] v);
      logic signed [ProdWidth+1:0] hi;
      logic signed [ProdWidth+1:0] lo;
      hi = (ProdWidth+2)'(64'sh7fffffff);
      lo = -(ProdWidth+2)'(64'sh80000000);
      if (v > hi) return 32'sh7fffffff;
      else if (v < lo) return 32'sh80000000;
      else return v[StateWidth-1:0];
   endfunction

endpackage
`default_nettype wire

// ----- rtl/takf_div.sv -----
// Restoring signed divider for the Kalman gains
`default_nettype none
module takf_div (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic signed [takf_pkg::StateWidth-1:0] num,
   input  wire logic signed [takf_pkg::StateWidth+1:0] den,
   output logic                                   busy,
   output logic signed [takf_pkg::StateWidth-1:0] quo
);
   import takf_pkg::*;

   // Dividend num*2^24 spans 56 bits, divisor up to 34 bits
   localparam int NW = StateWidth + 24;
   localparam int DW = StateWidth + 2;
   localparam int CW = $clog2(NW + 1);

   logic [NW-1:0]  rem_num_ff, rem_num_in;
   logic [DW:0]    rem_ff, rem_in;
   logic [DW-1:0]  dabs_ff, dabs_in;
   logic [NW-1:0]  q_ff, q_in;
   logic           neg_ff, neg_in, zero_ff, zero_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic           busy_ff, busy_in;
   logic [DW:0]    trial;
   logic [DW:0]    shifted;
   logic signed [NW:0] qs;

   always_comb begin
      rem_num_in = rem_num_ff;
      rem_in = rem_ff;
      dabs_in = dabs_ff;
      q_in = q_ff;
      neg_in = neg_ff;
      zero_in = zero_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      shifted = {rem_ff[DW-1:0], rem_num_ff[NW-1]};
      trial = shifted - {1'b0, dabs_ff};
      if (start) begin
         rem_num_in = {(num[StateWidth-1] ? NW'(-num) : NW'(num))} << 24;
         dabs_in = den[DW-1] ? DW'(-den) : DW'(den);
         neg_in = num[StateWidth-1] ^ den[DW-1];
         zero_in = (den == '0);
         rem_in = '0;
         q_in = '0;
         cnt_in = CW'(NW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // one quotient bit per cycle
         rem_num_in = rem_num_ff << 1;
         if (!trial[DW]) begin
            rem_in = trial;
            q_in = {q_ff[NW-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            q_in = {q_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
      rem_num_ff <= rem_num_in;
      rem_ff <= rem_in;
      dabs_ff <= dabs_in;
      q_ff <= q_in;
      neg_ff <= neg_in;
      zero_ff <= zero_in;
   end

   // Apply sign and saturate; a zero divisor gives zero
   always_comb begin
      qs = neg_ff ? -$signed({1'b0, q_ff}) : $signed({1'b0, q_ff});
      if (zero_ff) quo = '0;
      else quo = sat32((ProdWidth+2)'(qs));
   end
   assign busy = busy_ff;
endmodule
`default_nettype wire

// ----- rtl/takf_datapath.sv -----
// Datapath: per-axis state, shared multiplier, gain divider
`default_nettype none
module takf_datapath #(
   parameter int NUM_AXES = takf_pkg::NumAxesDefault
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire takf_pkg::takf_cmd_type             cmd,
   output takf_pkg::takf_sts_type                  sts,
   input  wire logic                               csr_we,
   input  wire logic [takf_pkg::CfgIdxWidth-1:0]   csr_idx,
   input  wire logic [takf_pkg::CfgWidth-1:0]      csr_wdata,
   input  wire logic                               req_axis,
   input  wire logic signed [takf_pkg::AccWidth-1:0] req_acc_angle,
   input  wire logic signed [takf_pkg::StateWidth-1:0] req_gyro_rate,
   input  wire logic [takf_pkg::DtWidth-1:0]       req_dt_sec,
   output logic signed [takf_pkg::StateWidth-1:0]  rsp_angle_out,
   output logic signed [takf_pkg::StateWidth-1:0]  rsp_bias_out
);
   import takf_pkg::*;

   localparam int AW = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
   localparam int PW = ProdWidth + 2;
   localparam int AOW = StateWidth + 1;
   localparam int BOW = StateWidth + 2;
   typedef logic signed [StateWidth-1:0] w_type;

   logic [CfgWidth-1:0] q_angle_ff, q_gyro_ff, r_angle_ff;
   w_type ang_st_ff [NUM_AXES], bia_st_ff [NUM_AXES];
   w_type c00_st_ff [NUM_AXES], c01_st_ff [NUM_AXES];
   w_type c10_st_ff [NUM_AXES], c11_st_ff [NUM_AXES];

   logic [AW-1:0] ax_ff;
   logic [AW-1:0] ax_in;
   logic signed [AccWidth-1:0] acc_ff;
   w_type rate_ff;
   logic [DtWidth-1:0] dt_ff;
   w_type ang_ff, bia_ff, p00_ff, p01_ff, p10_ff, p11_ff;
   w_type c00_ff, c01_ff, c10_ff, c11_ff;
   w_type k0_ff, k1_ff;
   w_type rsp_angle_ff, rsp_bias_ff;
   logic signed [StateWidth+1:0] s_ff;
   logic signed [StateWidth:0]   y_ff;
   logic signed [PW-1:0] prod_ff;
   logic [3:0] psel_ff;
   logic signed [PW-1:0] prod_in;
   logic signed [PW-1:0] fl;
   logic signed [AOW-1:0] pa_op;
   logic signed [BOW-1:0] pb_op;
   logic signed [PW-1:0] qa_dt;
   logic div_start_d;
   w_type quo;
   logic div_busy;

   // Clamp axis to the last filter
   always_comb begin
      if (NUM_AXES == 1) ax_in = '0;
      else if ({{(32-1){1'b0}}, req_axis} >= 32'(NUM_AXES)) ax_in = AW'(NUM_AXES - 1);
      else ax_in = AW'(req_axis);
   end

   // Select operands for the shared 33 by 34 bit multiplier
   always_comb begin
      pa_op = AOW'($signed({1'b0, dt_ff}));
      pb_op = '0;
      case (cmd.mul_sel)
         MUL_DT_RATE: pb_op = BOW'(rate_ff) - BOW'(bia_ff);
         MUL_DT_QA:   pb_op = BOW'($signed({1'b0, q_angle_ff}));
         MUL_DT_C01:  pb_op = BOW'(c10_ff) + BOW'(c01_ff);
         MUL_DT_C11:  pb_op = BOW'(c11_ff);
         MUL_DT_QG:   pb_op = BOW'($signed({1'b0, q_gyro_ff}));
         MUL_K0_Y:    begin pa_op = AOW'(k0_ff); pb_op = BOW'(y_ff); end
         MUL_K1_Y:    begin pa_op = AOW'(k1_ff); pb_op = BOW'(y_ff); end
         MUL_K0_P00:  begin pa_op = AOW'(k0_ff); pb_op = BOW'(p00_ff); end
         MUL_K0_P01:  begin pa_op = AOW'(k0_ff); pb_op = BOW'(p01_ff); end
         MUL_K1_P00:  begin pa_op = AOW'(k1_ff); pb_op = BOW'(p00_ff); end
         MUL_K1_P01:  begin pa_op = AOW'(k1_ff); pb_op = BOW'(p01_ff); end
         default:     pb_op = '0;
      endcase
      prod_in = PW'(pa_op) * PW'(pb_op);
   end

   // Floor shift of the registered product
   always_comb begin
      fl = prod_ff >>> 24;
   end

   takf_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start_d),
      .num   (cmd.div_sel ? p10_ff : p00_ff),
      .den   (s_ff),
      .busy  (div_busy),
      .quo   (quo)
   );
   assign sts.div_busy = div_busy | div_start_d;

   always_ff @(posedge clock) begin
      if (reset) begin
         q_angle_ff <= CfgWidth'(167772);
         q_gyro_ff <= CfgWidth'(5033);
         r_angle_ff <= CfgWidth'(167772);
         div_start_d <= 1'b0;
         for (int i = 0; i < NUM_AXES; i++) begin
            ang_st_ff[i] <= '0; bia_st_ff[i] <= '0;
            c00_st_ff[i] <= '0; c01_st_ff[i] <= '0;
            c10_st_ff[i] <= '0; c11_st_ff[i] <= '0;
         end
      end else begin
         div_start_d <= cmd.div_start;
         if (csr_we) begin
            case (csr_idx)
               REG_Q_ANGLE: q_angle_ff <= csr_wdata;
               REG_Q_GYRO:  q_gyro_ff <= csr_wdata;
               REG_R_ANGLE: r_angle_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.store) begin
            ang_st_ff[ax_ff] <= ang_ff; bia_st_ff[ax_ff] <= bia_ff;
            c00_st_ff[ax_ff] <= c00_ff; c01_st_ff[ax_ff] <= c01_ff;
            c10_st_ff[ax_ff] <= c10_ff; c11_st_ff[ax_ff] <= c11_ff;
         end
      end
   end

   // Sequenced datapath registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ax_ff <= ax_in;
         acc_ff <= req_acc_angle;
         rate_ff <= req_gyro_rate;
         dt_ff <= req_dt_sec;
         ang_ff <= ang_st_ff[ax_in];
         bia_ff <= bia_st_ff[ax_in];
         c00_ff <= c00_st_ff[ax_in];
         c01_ff <= c01_st_ff[ax_in];
         c10_ff <= c10_st_ff[ax_in];
         c11_ff <= c11_st_ff[ax_in];
      end
      if (cmd.mul_go) begin
         prod_ff <= prod_in;
         psel_ff <= cmd.mul_sel;
      end
      if (cmd.apply) begin
         case (psel_ff)
            MUL_DT_RATE: ang_ff <= sat32(PW'(ang_ff) + fl);
            MUL_DT_QA:   qa_dt <= prod_ff;
            MUL_DT_C01:  p00_ff <= sat32(PW'(c00_ff) + ((qa_dt - prod_ff) >>> 24));
            MUL_DT_C11: begin
               p01_ff <= sat32(PW'(c01_ff) + ((-prod_ff) >>> 24));
               p10_ff <= sat32(PW'(c10_ff) + ((-prod_ff) >>> 24));
            end
            MUL_DT_QG:   p11_ff <= sat32(PW'(c11_ff) + fl);
            MUL_K0_Y:    ang_ff <= sat32(PW'(ang_ff) + fl);
            MUL_K1_Y:    bia_ff <= sat32(PW'(bia_ff) + fl);
            MUL_K0_P00:  c00_ff <= sat32(PW'(p00_ff) - fl);
            MUL_K0_P01:  c01_ff <= sat32(PW'(p01_ff) - fl);
            MUL_K1_P00:  c10_ff <= sat32(PW'(p10_ff) - fl);
            MUL_K1_P01:  c11_ff <= sat32(PW'(p11_ff) - fl);
            default: ;
         endcase
      end
      if (cmd.pred_p00) begin
         s_ff <= (StateWidth+2)'(p00_ff) + (StateWidth+2)'($signed({1'b0, r_angle_ff}));
         y_ff <= (StateWidth+1)'(acc_ff) - (StateWidth+1)'(ang_ff);
      end
      if (cmd.k0_load) k0_ff <= quo;
      if (cmd.k1_load) k1_ff <= quo;
      // hold the response apart from the axis state
      if (cmd.store) begin
         rsp_angle_ff <= ang_ff;
         rsp_bias_ff <= bia_ff;
      end
   end

   assign rsp_angle_out = rsp_angle_ff;
   assign rsp_bias_out  = rsp_bias_ff;
endmodule
`default_nettype wire

// ----- rtl/takf_ctrl.sv -----
// Controller: sequences predict, gain division and update
`default_nettype none
module takf_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output takf_pkg::takf_cmd_type      cmd,
   input  wire takf_pkg::takf_sts_type sts
);
   import takf_pkg::*;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_MUL   = 4'd1;
   localparam logic [3:0] ST_APPLY = 4'd2;
   localparam logic [3:0] ST_SPRE  = 4'd3;
   localparam logic [3:0] ST_DIV0  = 4'd4;
   localparam logic [3:0] ST_WAIT0 = 4'd5;
   localparam logic [3:0] ST_K0    = 4'd6;
   localparam logic [3:0] ST_DIV1  = 4'd7;
   localparam logic [3:0] ST_WAIT1 = 4'd8;
   localparam logic [3:0] ST_K1    = 4'd9;
   localparam logic [3:0] ST_STORE = 4'd10;
   localparam logic [3:0] ST_DONE  = 4'd11;

   logic [3:0] state_ff, state_in;
   logic [3:0] sel_ff, sel_in;
   logic       done_ff, done_in;

   always_comb begin
      state_in = state_ff;
      sel_in = sel_ff;
      done_in = done_ff;
      cmd = '0;
      cmd.mul_sel = sel_ff;
      req_ready = (state_ff == ST_IDLE);
      // drop the held response once it is taken
      if (done_ff && rsp_ready) done_in = 1'b0;
      case (state_ff)
         ST_IDLE: if (req_valid) begin
            cmd.load = 1'b1;
            sel_in = MUL_DT_RATE;
            state_in = ST_MUL;
         end
         ST_MUL: begin cmd.mul_go = 1'b1; state_in = ST_APPLY; end
         ST_APPLY: begin
            cmd.apply = 1'b1;
            case (sel_ff)
               MUL_DT_QG:  state_in = ST_SPRE;
               MUL_K1_P01: state_in = ST_STORE;
               default: begin sel_in = sel_ff + 4'd1; state_in = ST_MUL; end
            endcase
         end
         ST_SPRE: begin cmd.pred_p00 = 1'b1; state_in = ST_DIV0; end
         ST_DIV0: begin cmd.div_start = 1'b1; state_in = ST_WAIT0; end
         ST_WAIT0: if (!sts.div_busy) begin
            cmd.k0_load = 1'b1;
            state_in = ST_K0;
         end
         ST_K0: begin
            // start the K1 divide
            cmd.div_sel = 1'b1; cmd.div_start = 1'b1; state_in = ST_WAIT1;
         end
         ST_WAIT1: begin
            cmd.div_sel = 1'b1;
            if (!sts.div_busy) begin
               cmd.k1_load = 1'b1;
               sel_in = MUL_K1_Y;
               state_in = ST_K1;
            end
         end
         ST_K1: begin sel_in = MUL_K0_Y; state_in = ST_MUL; end
         // hold the store until the previous response is gone or leaves now
         ST_STORE: if (!done_ff || rsp_ready) begin
            cmd.store = 1'b1; done_in = 1'b1; state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
      rsp_valid = done_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sel_ff <= MUL_DT_QG;
         done_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sel_ff <= sel_in;
         done_ff <= done_in;
      end
   end
endmodule
`default_nettype wire

// ----- rtl/tilt_angle_kalman_filter_core.sv -----
// Top level of the two-state tilt angle Kalman filter
// Each request runs the predict multiply/apply pairs, S and y, two gain divides of 56 steps
//    each, the update multiply/apply pairs (11 pairs in all) and the store.
// req_ready is high only while idle, so one request is processed at a time.
// The response sits in its own register; only the next store waits for it to be taken.
// Reset (synchronous, active high) clears all axis state and loads default noise values.
`default_nettype none
module tilt_angle_kalman_filter_core #(
   parameter int NUM_AXES = takf_pkg::NumAxesDefault
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic                                 req_axis,
   input  wire logic signed [takf_pkg::AccWidth-1:0] req_acc_angle,
   input  wire logic signed [takf_pkg::StateWidth-1:0] req_gyro_rate,
   input  wire logic [takf_pkg::DtWidth-1:0]         req_dt_sec,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic signed [takf_pkg::StateWidth-1:0]    rsp_angle_out,
   output logic signed [takf_pkg::StateWidth-1:0]    rsp_bias_out,
   input  wire logic                                 csr_we,
   input  wire logic [takf_pkg::CfgIdxWidth-1:0]     csr_idx,
   input  wire logic [takf_pkg::CfgWidth-1:0]        csr_wdata
);
   import takf_pkg::*;

   takf_cmd_type cmd;
   takf_sts_type sts;

   takf_ctrl u_ctrl (
      .clock (clock), .reset (reset),
      .req_valid (req_valid), .req_ready (req_ready),
      .rsp_valid (rsp_valid), .rsp_ready (rsp_ready),
      .cmd (cmd), .sts (sts)
   );

   takf_datapath #(.NUM_AXES(NUM_AXES)) u_dp (
      .clock (clock), .reset (reset), .cmd (cmd), .sts (sts),
      .csr_we (csr_we), .csr_idx (csr_idx), .csr_wdata (csr_wdata),
      .req_axis (req_axis), .req_acc_angle (req_acc_angle),
      .req_gyro_rate (req_gyro_rate), .req_dt_sec (req_dt_sec),
      .rsp_angle_out (rsp_angle_out), .rsp_bias_out (rsp_bias_out)
   );

   // A waiting response keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_angle_out) && $stable(rsp_bias_out))
      else $error("response payload changed while waiting");

   // A response stays until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("response dropped");

   // Write-back only from the store step, never with a load
   a_store_load: assert property (@(posedge clock) disable iff (reset)
      !(cmd.store && cmd.load)) else $error("store and load together");
endmodule
`default_nettype wire
